[hdl/eho_pkg.sv]
// Shared types, constants and tables of the encoder heading odometry block.
package eho_pkg;

	// Register map: one register, selected by byte address bit 2.
	localparam logic ADDR_WHEEL_DIAM = 1'b0;
	localparam int unsigned PADDR_W = 3;
	localparam logic [9:0] WHEEL_DIAM_RESET = 10'd102;

	// Distance scale pi*256/360 in Q24 and CORDIC gain compensation in Q24.
	localparam logic [25:0] DIST_K = 26'd37480660;
	localparam logic [25:0] GAIN_K = 26'd10188014;

	// Heading reduction: offset that maps the 16-bit heading to a positive
	// value congruent modulo 3600, and floor(2^26 / 3600) for the quotient.
	localparam logic [16:0] HEAD_OFFSET = 17'd3232;
	localparam logic [14:0] HEAD_RECIP = 15'd18641;
	localparam logic [16:0] HEAD_MOD = 17'd3600;

	// Width of the sequencer step counter.
	localparam int unsigned STEP_W = 4;

	// Input word: one sample of both wheels and the heading.
	typedef struct packed {
		logic signed [15:0] turns_x;
		logic signed [15:0] angle_x;
		logic signed [15:0] turns_y;
		logic signed [15:0] angle_y;
		logic signed [15:0] heading_tenths;
	} in_word_t;

	// Output word: accumulated field position.
	typedef struct packed {
		logic signed [47:0] position_x;
		logic signed [47:0] position_y;
	} out_word_t;

	// Operand pair for the shared multiplier.
	typedef enum logic [3:0] {
		MS_MAGX_D,
		MS_MAGY_D,
		MS_PXLO_K,
		MS_PXHI_K,
		MS_PYLO_K,
		MS_PYHI_K,
		MS_AXLO_G,
		MS_AXHI_G,
		MS_AYLO_G,
		MS_AYHI_G
	} mul_sel_t;

	// Product accumulator operation.
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD_HI
	} acc_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     px_en;
		logic     py_en;
		logic     dist_x_en;
		logic     dist_y_en;
		logic     diff_en;
		logic     map_en;
		logic     gx_en;
		logic     gy_en;
		logic     rot_init;
		logic     rot_en;
		logic     round_en;
		logic     accum_en;
	} eho_cmd_t;

	// CORDIC angle table, atan(2^-i) in 0.1 degree Q20.
	function automatic logic [28:0] atan_val(input logic [4:0] i);
		logic [28:0] v;
		case (i)
			5'd0:    v = 29'd471859200;
			5'd1:    v = 29'd278554751;
			5'd2:    v = 29'd147180680;
			5'd3:    v = 29'd74711211;
			5'd4:    v = 29'd37500584;
			5'd5:    v = 29'd18768573;
			5'd6:    v = 29'd9386577;
			5'd7:    v = 29'd4693575;
			5'd8:    v = 29'd2346823;
			5'd9:    v = 29'd1173416;
			5'd10:   v = 29'd586709;
			5'd11:   v = 29'd293354;
			5'd12:   v = 29'd146677;
			5'd13:   v = 29'd73339;
			5'd14:   v = 29'd36669;
			5'd15:   v = 29'd18335;
			5'd16:   v = 29'd9167;
			5'd17:   v = 29'd4584;
			5'd18:   v = 29'd2292;
			5'd19:   v = 29'd1146;
			5'd20:   v = 29'd573;
			5'd21:   v = 29'd286;
			5'd22:   v = 29'd143;
			5'd23:   v = 29'd72;
			default: v = 29'd0;
		endcase
		return v;
	endfunction

endpackage

[hdl/eho_ctrl.sv]
// Sequencer that steps the odometry datapath through one word.
module eho_ctrl #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	output logic                            out_valid,
	input  logic                            out_stall,
	output eho_pkg::eho_cmd_t               cmd,
	output logic [$clog2(CORDIC_STEPS)-1:0] idx
);
	import eho_pkg::*;

	localparam int unsigned IW = $clog2(CORDIC_STEPS);
	localparam logic [IW-1:0] IDX_LAST = IW'(CORDIC_STEPS - 1);
	localparam logic [STEP_W-1:0] DIST_LAST = STEP_W'(8);
	localparam logic [STEP_W-1:0] GAIN_LAST = STEP_W'(5);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIST  = 8'b0000_0010,
		ST_DIFF  = 8'b0000_0100,
		ST_MAP   = 8'b0000_1000,
		ST_GAIN  = 8'b0001_0000,
		ST_ROT   = 8'b0010_0000,
		ST_ROUND = 8'b0100_0000,
		ST_ACCUM = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [IW-1:0]     idx_q, idx_d;
	logic              out_valid_q;
	logic              out_busy;

	// The output register is blocked while a word waits and is not taken.
	assign out_busy = out_valid_q && out_stall;

	// Next state and counters.
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE: begin
				step_d = '0;
				if (in_valid) begin
					state_d = ST_DIST;
				end
			end
			ST_DIST: begin
				if (step_q == DIST_LAST) begin
					state_d = ST_DIFF;
					step_d  = '0;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			ST_DIFF: begin
				state_d = ST_MAP;
			end
			ST_MAP: begin
				state_d = ST_GAIN;
				step_d  = '0;
			end
			ST_GAIN: begin
				if (step_q == GAIN_LAST) begin
					state_d = ST_ROT;
					step_d  = '0;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			ST_ROT: begin
				if (idx_q == IDX_LAST) begin
					state_d = ST_ROUND;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + IW'(1);
				end
			end
			ST_ROUND: begin
				if (!out_busy) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
				step_d  = '0;
				idx_d   = '0;
			end
		endcase
	end

	// Datapath commands; the multiplier schedule interleaves both wheels.
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MS_MAGX_D;
		cmd.acc_op  = ACC_HOLD;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_DIST: begin
				case (step_q)
					4'd1: cmd.mul_sel = MS_MAGX_D;
					4'd2: begin
						cmd.mul_sel = MS_MAGY_D;
						cmd.px_en   = 1'b1;
					end
					4'd3: begin
						cmd.mul_sel = MS_PXLO_K;
						cmd.py_en   = 1'b1;
					end
					4'd4: begin
						cmd.mul_sel = MS_PXHI_K;
						cmd.acc_op  = ACC_LOAD;
					end
					4'd5: begin
						cmd.mul_sel = MS_PYLO_K;
						cmd.acc_op  = ACC_ADD_HI;
					end
					4'd6: begin
						cmd.mul_sel   = MS_PYHI_K;
						cmd.dist_x_en = 1'b1;
						cmd.acc_op    = ACC_LOAD;
					end
					4'd7: cmd.acc_op = ACC_ADD_HI;
					4'd8: cmd.dist_y_en = 1'b1;
					default: cmd.acc_op = ACC_HOLD;
				endcase
			end
			ST_DIFF: cmd.diff_en = 1'b1;
			ST_MAP:  cmd.map_en = 1'b1;
			ST_GAIN: begin
				case (step_q)
					4'd0: cmd.mul_sel = MS_AXLO_G;
					4'd1: begin
						cmd.mul_sel = MS_AXHI_G;
						cmd.acc_op  = ACC_LOAD;
					end
					4'd2: begin
						cmd.mul_sel = MS_AYLO_G;
						cmd.acc_op  = ACC_ADD_HI;
					end
					4'd3: begin
						cmd.mul_sel = MS_AYHI_G;
						cmd.gx_en   = 1'b1;
						cmd.acc_op  = ACC_LOAD;
					end
					4'd4: cmd.acc_op = ACC_ADD_HI;
					4'd5: begin
						cmd.gy_en    = 1'b1;
						cmd.rot_init = 1'b1;
					end
					default: cmd.acc_op = ACC_HOLD;
				endcase
			end
			ST_ROT:   cmd.rot_en = 1'b1;
			ST_ROUND: cmd.round_en = 1'b1;
			ST_ACCUM: cmd.accum_en = 1'b1;
			default:  cmd.load = 1'b0;
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			idx_q   <= idx_d;
		end
	end

	// Output valid flag: set when a new position is written, cleared on take.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_ACCUM) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign idx       = idx_q;

	// The position is never updated over a word that is still waiting.
	a_accum_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accum_en |-> !out_valid_q)
		else $error("position updated while the output word is pending");

	// An accepted word starts the distance phase.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DIST && step_q == '0))
		else $error("accepted word did not start the sequence");

	// The last rotation step leads to rounding with a cleared counter.
	a_rot_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT && idx_q == IDX_LAST) |=> (state_q == ST_ROUND && idx_q == '0))
		else $error("rotation did not end after the last step");

	// Every position update is offered on the output in the next cycle.
	a_accum_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCUM) |=> out_valid_q)
		else $error("position update not presented");

endmodule

[hdl/eho_datapath.sv]
// Odometry datapath: wheel distances, heading reduction, CORDIC and position.
module eho_datapath #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  eho_pkg::eho_cmd_t               cmd,
	input  logic [$clog2(CORDIC_STEPS)-1:0] idx,
	input  logic                            cfg_wr,
	input  logic [9:0]                      cfg_data,
	output logic [9:0]                      wheel_diam,
	input  eho_pkg::in_word_t               in_word,
	output eho_pkg::out_word_t              out_word
);
	import eho_pkg::*;

	// Configuration and position state.
	logic [9:0]         diam_q;
	logic               seen_q;
	logic signed [47:0] pos_x_q, pos_y_q;

	// Captured sample and wheel magnitudes.
	logic signed [24:0] tx_q, ty_q;
	logic signed [15:0] hd_q;
	logic [23:0]        magx_q, magy_q;
	logic               negx_q, negy_q;

	// Shared multiplier and accumulator.
	logic [23:0] mul_a;
	logic [25:0] mul_b;
	logic [49:0] mul_p;
	logic [49:0] mul_q;
	logic [59:0] acc_q;
	logic [33:0] px_q, py_q;

	// Distances and displacement.
	logic [59:0]        dist_r;
	logic signed [35:0] dist_mag, dist_val;
	logic               dist_neg;
	logic signed [35:0] dist_x_q, dist_y_q, prev_x_q, prev_y_q;
	logic signed [36:0] dx_q, dy_q;
	logic signed [36:0] sel_x, sel_y, abs_x, abs_y;
	logic               neg_x, neg_y;
	logic [35:0]        ax_q, ay_q;
	logic               sx_q, sy_q;
	logic signed [63:0] gain_val;

	// Heading reduction pipeline.
	logic [16:0]        hv_s1, hv_s2;
	logic [31:0]        hp;
	logic [4:0]         hq_s2;
	logic [12:0]        hr_s3;
	logic [11:0]        h_s4;
	logic [2:0]         qs;
	logic signed [12:0] res_full;
	logic [1:0]         quad_s5;
	logic signed [11:0] res_s5;

	// CORDIC and rounding.
	logic signed [63:0] cx_q, cy_q, xs, ys;
	logic signed [31:0] z_q, atan_z;
	logic signed [63:0] rxs, rys;
	logic [47:0]        rx_q, ry_q;

	// Turns and extra degrees as one signed count of degrees.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tx_q <= 25'(in_word.turns_x) * 25'sd360 + 25'(in_word.angle_x);
			ty_q <= 25'(in_word.turns_y) * 25'sd360 + 25'(in_word.angle_y);
			hd_q <= in_word.heading_tenths;
		end
	end

	// Magnitude and sign of each wheel count.
	always_ff @(posedge clk) begin
		negx_q <= tx_q[24];
		negy_q <= ty_q[24];
		magx_q <= tx_q[24] ? 24'(-tx_q) : tx_q[23:0];
		magy_q <= ty_q[24] ? 24'(-ty_q) : ty_q[23:0];
	end

	// Heading modulo 3600 through a reciprocal quotient and one correction.
	assign hp = hv_s1 * HEAD_RECIP;

	always_comb begin
		qs = 3'(h_s4 >= 12'd450) + 3'(h_s4 >= 12'd1350) + 3'(h_s4 >= 12'd2250)
			+ 3'(h_s4 >= 12'd3150);
		case (qs)
			3'd0:    res_full = signed'({1'b0, h_s4});
			3'd1:    res_full = signed'({1'b0, h_s4}) - 13'sd900;
			3'd2:    res_full = signed'({1'b0, h_s4}) - 13'sd1800;
			3'd3:    res_full = signed'({1'b0, h_s4}) - 13'sd2700;
			3'd4:    res_full = signed'({1'b0, h_s4}) - 13'sd3600;
			default: res_full = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		hv_s1   <= 17'({~hd_q[15], hd_q[14:0]}) + HEAD_OFFSET;
		hv_s2   <= hv_s1;
		hq_s2   <= hp[30:26];
		hr_s3   <= 13'(hv_s2 - 17'(hq_s2) * HEAD_MOD);
		h_s4    <= (hr_s3 >= 13'(HEAD_MOD)) ? 12'(hr_s3 - 13'(HEAD_MOD)) : hr_s3[11:0];
		quad_s5 <= qs[1:0];
		res_s5  <= res_full[11:0];
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = magx_q;
		mul_b = 26'(diam_q);
		case (cmd.mul_sel)
			MS_MAGX_D: begin
				mul_a = magx_q;
				mul_b = 26'(diam_q);
			end
			MS_MAGY_D: begin
				mul_a = magy_q;
				mul_b = 26'(diam_q);
			end
			MS_PXLO_K: begin
				mul_a = 24'(px_q[17:0]);
				mul_b = DIST_K;
			end
			MS_PXHI_K: begin
				mul_a = 24'(px_q[33:18]);
				mul_b = DIST_K;
			end
			MS_PYLO_K: begin
				mul_a = 24'(py_q[17:0]);
				mul_b = DIST_K;
			end
			MS_PYHI_K: begin
				mul_a = 24'(py_q[33:18]);
				mul_b = DIST_K;
			end
			MS_AXLO_G: begin
				mul_a = 24'(ax_q[17:0]);
				mul_b = GAIN_K;
			end
			MS_AXHI_G: begin
				mul_a = 24'(ax_q[35:18]);
				mul_b = GAIN_K;
			end
			MS_AYLO_G: begin
				mul_a = 24'(ay_q[17:0]);
				mul_b = GAIN_K;
			end
			MS_AYHI_G: begin
				mul_a = 24'(ay_q[35:18]);
				mul_b = GAIN_K;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Multiplier output register, partial products and accumulator.
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (cmd.px_en) begin
			px_q <= mul_q[33:0];
		end
		if (cmd.py_en) begin
			py_q <= mul_q[33:0];
		end
		case (cmd.acc_op)
			ACC_LOAD:   acc_q <= 60'(mul_q);
			ACC_ADD_HI: acc_q <= acc_q + {mul_q[41:0], 18'd0};
			default:    acc_q <= acc_q;
		endcase
	end

	// Distance rounded half away from zero, with the sign of the count.
	assign dist_r   = acc_q + 60'd8388608;
	assign dist_mag = signed'({1'b0, dist_r[58:24]});
	assign dist_neg = cmd.dist_x_en ? negx_q : negy_q;
	assign dist_val = dist_neg ? -dist_mag : dist_mag;

	always_ff @(posedge clk) begin
		if (cmd.dist_x_en) begin
			dist_x_q <= dist_val;
		end
		if (cmd.dist_y_en) begin
			dist_y_q <= dist_val;
		end
	end

	// Displacement since the previous sample; zero on the first one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (cmd.diff_en) begin
			seen_q   <= 1'b1;
			prev_x_q <= dist_x_q;
			prev_y_q <= dist_y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.diff_en) begin
			dx_q <= seen_q ? 37'(dist_x_q) - 37'(prev_x_q) : '0;
			dy_q <= seen_q ? 37'(dist_y_q) - 37'(prev_y_q) : '0;
		end
	end

	// Exact quarter turn, kept as magnitude and sign for the gain multiply.
	always_comb begin
		case (quad_s5)
			2'd1: begin
				sel_x = dy_q; neg_x = 1'b1;
				sel_y = dx_q; neg_y = 1'b0;
			end
			2'd2: begin
				sel_x = dx_q; neg_x = 1'b1;
				sel_y = dy_q; neg_y = 1'b1;
			end
			2'd3: begin
				sel_x = dy_q; neg_x = 1'b0;
				sel_y = dx_q; neg_y = 1'b1;
			end
			default: begin
				sel_x = dx_q; neg_x = 1'b0;
				sel_y = dy_q; neg_y = 1'b0;
			end
		endcase
		abs_x = sel_x[36] ? -sel_x : sel_x;
		abs_y = sel_y[36] ? -sel_y : sel_y;
	end

	always_ff @(posedge clk) begin
		if (cmd.map_en) begin
			ax_q <= abs_x[35:0];
			ay_q <= abs_y[35:0];
			sx_q <= sel_x[36] ^ neg_x;
			sy_q <= sel_y[36] ^ neg_y;
		end
	end

	// Gain-scaled vector with its sign restored, then CORDIC iterations.
	assign gain_val = signed'({4'd0, acc_q});
	assign xs       = cx_q >>> idx;
	assign ys       = cy_q >>> idx;
	assign atan_z   = signed'({3'd0, atan_val(5'(idx))});

	always_ff @(posedge clk) begin
		if (cmd.gx_en) begin
			cx_q <= sx_q ? -gain_val : gain_val;
		end else if (cmd.rot_en) begin
			cx_q <= z_q[31] ? cx_q + ys : cx_q - ys;
		end
		if (cmd.gy_en) begin
			cy_q <= sy_q ? -gain_val : gain_val;
		end else if (cmd.rot_en) begin
			cy_q <= z_q[31] ? cy_q - xs : cy_q + xs;
		end
		if (cmd.rot_init) begin
			z_q <= {res_s5, 20'd0};
		end else if (cmd.rot_en) begin
			z_q <= z_q[31] ? z_q + atan_z : z_q - atan_z;
		end
	end

	// Round the Q24 result to whole 1/256 mm.
	assign rxs = (cx_q + 64'sd8388608) >>> 24;
	assign rys = (cy_q + 64'sd8388608) >>> 24;

	always_ff @(posedge clk) begin
		if (cmd.round_en) begin
			rx_q <= rxs[47:0];
			ry_q <= rys[47:0];
		end
	end

	// Wheel diameter register and wrapping position accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diam_q  <= WHEEL_DIAM_RESET;
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else begin
			if (cfg_wr) begin
				diam_q <= cfg_data;
			end
			if (cmd.accum_en) begin
				pos_x_q <= pos_x_q + signed'(rx_q);
				pos_y_q <= pos_y_q + signed'(ry_q);
			end
		end
	end

	assign wheel_diam          = diam_q;
	assign out_word.position_x = pos_x_q;
	assign out_word.position_y = pos_y_q;

endmodule

[hdl/encoder_heading_odometry.sv]
// Top level of the encoder heading odometry block: register port and core.
//
//   channel   direction  handshake           contents
//   in        sink       in_valid/in_stall   in_word: wheel turns, degrees, heading
//   out       source     out_valid/out_stall out_word: position_x, position_y
//   register  APB        psel/penable/pready wheel_diameter_mm at byte address 0
//
// A word passes the distance, difference, mapping, gain, CORDIC rotation,
// rounding and position update steps before the next word is accepted.
// The result is valid from the cycle after the position update.
// Reset clears the position, the first-sample flag and sets the diameter to 102.
// A stalled output word holds the sequence before the position update; no
// new word is accepted until that update is done.
module encoder_heading_odometry #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  eho_pkg::in_word_t               in_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output eho_pkg::out_word_t              out_word,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [eho_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import eho_pkg::*;

	localparam int unsigned IW = $clog2(CORDIC_STEPS);

	eho_cmd_t      cmd;
	logic [IW-1:0] idx;
	logic          cfg_wr;
	logic [9:0]    wheel_diam;

	// Register port decode; bit 2 of the byte address selects the register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ADDR_WHEEL_DIAM);
	assign prdata = (paddr[2] == ADDR_WHEEL_DIAM) ? 32'(wheel_diam) : 32'd0;

	eho_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.idx      (idx)
	);

	eho_datapath #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.cfg_wr    (cfg_wr),
		.cfg_data  (pwdata[9:0]),
		.wheel_diam(wheel_diam),
		.in_word   (in_word),
		.out_word  (out_word)
	);

endmodule
